// ----- design/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants for the serial frame parser
// Holds the event codes, the result record, the configuration record and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    // Largest payload length the parser ever accepts, whatever the register says.
    localparam int unsigned MAX_PAYLOAD = 256;

    // Register map: word index taken from paddr[3:2].
    localparam logic [1:0] REG_START_BYTE  = 2'd0;
    localparam logic [1:0] REG_END_BYTE    = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0] START_BYTE_RESET  = 8'hAA;
    localparam logic [7:0] END_BYTE_RESET    = 8'h55;
    localparam logic [8:0] MAX_PAYLOAD_RESET = 9'd256;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2,
        EV_LEN_ERR = 2'd3
    } sfp_event_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [8:0] max_payload_len;
    } sfp_cfg_t;

    typedef struct packed {
        sfp_event_t  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [31:0] stamp;
        logic [7:0]  reserved_field;
        logic [7:0]  version_field;
        logic [15:0] frame_type;
        logic [47:0] device_address;
        logic [8:0]  payload_len;
        logic [15:0] sum_received;
        logic [15:0] sum_computed;
    } sfp_result_t;

endpackage

`default_nettype wire

// ----- design/serial_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// serial_frame_parser_core: byte-serial frame receiver with additive checksum
// Hunts for a start byte, collects the header, streams out payload bytes and
// reports frame good or frame bad at the end of a frame, or a length error.
// ----------------------------------------------------------------------------
// Use:
//   s_ channel: one received serial byte per request in s_tdata[7:0].
//   m_ channel: results. m_tuser carries the event code (payload byte, frame
//   good, frame bad, length error), m_tdata the payload byte, its index and
//   the header fields and checksums of the current frame.
//   APB port: start byte (0x0), end byte (0x4), payload length limit (0x8).
//   Write it only while no frame is in flight and all results are taken.
// Throughput and timing:
//   One byte per cycle while s_tready is high. The parse state machine decides
//   each byte combinationally, between its state registers and the result
//   register, which drives m_ (with the skid entry behind it under a stall).
// Stall:
//   A result register plus one skid entry absorb a stalled receiver; s_tready
//   drops only while the skid entry is occupied, and nothing is lost.
// Reset:
//   aresetn low (synchronous) returns the parser to hunting, empties the
//   result stages and loads the register reset values (0xAA, 0x55, 256).
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_parser_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [47:16] stamp,
    // [55:48] reserved_field, [63:56] version_field, [79:64] frame_type,
    // [127:80] device_address, [136:128] payload_len, [152:137] sum_received,
    // [168:153] sum_computed, [175:169] zero
    output logic [175:0]       m_tdata,
    output logic [1:0]         m_tuser,   // [1:0] event_res
    // Configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import sfp_pkg::*;

    sfp_cfg_t    cfg;
    logic        accept;
    logic        res_valid;
    sfp_result_t res;
    sfp_result_t m_res;

    // Configuration registers.
    sfp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the parser on every accepted request.
    assign accept = s_tvalid && s_tready;

    sfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Register the result; the skid entry keeps input flowing under a stall.
    sfp_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    // Event code on m_tuser; other result fields on m_tdata, first field lowest.
    assign m_tuser = m_res.event_res;
    assign m_tdata = {7'd0,
                      m_res.sum_computed,
                      m_res.sum_received,
                      m_res.payload_len,
                      m_res.device_address,
                      m_res.frame_type,
                      m_res.version_field,
                      m_res.reserved_field,
                      m_res.stamp,
                      m_res.payload_index,
                      m_res.payload_byte};

endmodule

`default_nettype wire

// ----- design/sfp_apb_regs.sv -----
// ----------------------------------------------------------------------------
// sfp_apb_regs: configuration registers behind an APB-style port
// Start byte, end byte and payload length limit, with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_apb_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output sfp_pkg::sfp_cfg_t  cfg
);
    import sfp_pkg::*;

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic [8:0] max_len_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_BYTE_RESET;
            end_reg     <= END_BYTE_RESET;
            max_len_reg <= MAX_PAYLOAD_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_BYTE:  start_reg   <= pwdata[7:0];
                REG_END_BYTE:    end_reg     <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_len_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:  prdata = {24'd0, start_reg};
            REG_END_BYTE:    prdata = {24'd0, end_reg};
            REG_MAX_PAYLOAD: prdata = {23'd0, max_len_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.start_byte      = start_reg;
    assign cfg.end_byte        = end_reg;
    assign cfg.max_payload_len = max_len_reg;

endmodule

`default_nettype wire

// ----- design/sfp_parser.sv -----
// ----------------------------------------------------------------------------
// sfp_parser: frame parse state machine
// Advances one byte per accepted request and forms at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    input  wire sfp_pkg::sfp_cfg_t cfg,
    output logic                 res_valid,
    output sfp_pkg::sfp_result_t res
);
    import sfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_STAMP, PH_RESERVED, PH_VERSION, PH_TYPE, PH_ADDR,
        PH_LEN, PH_PAYLOAD, PH_CHECK, PH_END
    } phase_t;

    localparam logic [8:0]  STAMP_BYTES = 9'd4;
    localparam logic [8:0]  TYPE_BYTES  = 9'd2;
    localparam logic [8:0]  ADDR_BYTES  = 9'd6;
    localparam logic [8:0]  SUM_BYTES   = 9'd2;
    localparam logic [16:0] MAX_LEN     = 17'(MAX_PAYLOAD);

    phase_t      phase_reg,   phase_next;
    logic [8:0]  cnt_reg,     cnt_next;
    logic [15:0] sum_reg,     sum_next;
    logic [31:0] stamp_reg,   stamp_next;
    logic [7:0]  rsv_reg,     rsv_next;
    logic [7:0]  ver_reg,     ver_next;
    logic [15:0] type_reg,    type_next;
    logic [47:0] addr_reg,    addr_next;
    logic [8:0]  len_reg,     len_next;
    logic [15:0] check_reg,   check_next;

    logic [8:0]  cnt_inc;
    logic [15:0] sum_add;
    logic [15:0] len_full;
    logic [16:0] limit;
    sfp_event_t  ev;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;

    assign cnt_inc  = cnt_reg + 9'd1;
    assign sum_add  = sum_reg + {8'd0, rx_byte};
    assign len_full = {rx_byte, len_reg[7:0]};
    assign limit    = ({8'd0, cfg.max_payload_len} > MAX_LEN) ? MAX_LEN
                                                              : {8'd0, cfg.max_payload_len};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        stamp_next = stamp_reg;
        rsv_next   = rsv_reg;
        ver_next   = ver_reg;
        type_next  = type_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        check_next = check_reg;
        res_valid  = 1'b0;
        ev         = EV_PAYLOAD;
        pbyte      = 8'd0;
        pidx       = 8'd0;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == cfg.start_byte) begin
                        cnt_next   = 9'd0;
                        sum_next   = {8'd0, rx_byte};
                        check_next = 16'd0;
                        phase_next = PH_STAMP;
                    end
                end
                PH_STAMP: begin
                    stamp_next[{cnt_reg[1:0], 3'b000} +: 8] = rx_byte;
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= STAMP_BYTES) begin
                        cnt_next   = 9'd0;
                        phase_next = PH_RESERVED;
                    end
                end
                PH_RESERVED: begin
                    rsv_next   = rx_byte;
                    sum_next   = sum_add;
                    phase_next = PH_VERSION;
                end
                PH_VERSION: begin
                    ver_next   = rx_byte;
                    sum_next   = sum_add;
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    type_next[{cnt_reg[0], 3'b000} +: 8] = rx_byte;
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= TYPE_BYTES) begin
                        cnt_next   = 9'd0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    addr_next[{cnt_reg[2:0], 3'b000} +: 8] = rx_byte;
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= ADDR_BYTES) begin
                        cnt_next   = 9'd0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    sum_next = sum_add;
                    if (!cnt_reg[0]) begin
                        len_next = {1'b0, rx_byte};
                        cnt_next = cnt_inc;
                    end else begin
                        len_next = len_full[8:0];
                        cnt_next = 9'd0;
                        if ({1'b0, len_full} > limit) begin
                            res_valid  = 1'b1;
                            ev         = EV_LEN_ERR;
                            phase_next = PH_HUNT;
                        end else if (len_full == 16'd0) begin
                            phase_next = PH_CHECK;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    sum_next  = sum_add;
                    cnt_next  = cnt_inc;
                    res_valid = 1'b1;
                    ev        = EV_PAYLOAD;
                    pbyte     = rx_byte;
                    pidx      = cnt_reg[7:0];
                    if (cnt_inc >= len_reg) begin
                        cnt_next   = 9'd0;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    check_next[{cnt_reg[0], 3'b000} +: 8] = rx_byte;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= SUM_BYTES) begin
                        cnt_next   = 9'd0;
                        phase_next = PH_END;
                    end
                end
                PH_END: begin
                    res_valid  = 1'b1;
                    phase_next = PH_HUNT;
                    ev = (rx_byte == cfg.end_byte && check_reg == sum_reg) ? EV_GOOD
                                                                            : EV_BAD;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        res.event_res      = ev;
        res.payload_byte   = pbyte;
        res.payload_index  = pidx;
        res.stamp          = stamp_next;
        res.reserved_field = rsv_next;
        res.version_field  = ver_next;
        res.frame_type     = type_next;
        res.device_address = addr_next;
        res.payload_len    = len_next;
        res.sum_received   = check_next;
        res.sum_computed   = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= 9'd0;
            sum_reg   <= 16'd0;
            check_reg <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            check_reg <= check_next;
        end
    end

    // Header fields are always rewritten before they are reported.
    always_ff @(posedge aclk) begin
        stamp_reg <= stamp_next;
        rsv_reg   <= rsv_next;
        ver_reg   <= ver_next;
        type_reg  <= type_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
    end

    a_result_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> accept)
        else $error("result formed without an accepted request");

    a_hunt_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_HUNT) |-> !res_valid)
        else $error("result formed while hunting");

    a_end_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_END) |=> phase_reg == PH_HUNT)
        else $error("end byte did not return to hunting");

    a_stamp_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STAMP |-> cnt_reg < STAMP_BYTES)
        else $error("timestamp byte count out of range");

endmodule

`default_nettype wire

// ----- design/sfp_out_skid.sv -----
// ----------------------------------------------------------------------------
// sfp_out_skid: result register with a skid stage
// Holds results while the receiver stalls so parsing can go on until the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_out_skid (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire sfp_pkg::sfp_result_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sfp_pkg::sfp_result_t out_data
);
    import sfp_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    sfp_result_t out_data_reg;
    sfp_result_t skid_data_reg;
    logic        drain;

    // Skid is empty whenever a request is accepted, so in_valid never meets a full skid.
    assign in_ready  = !skid_valid_reg;
    assign drain     = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (drain) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> !skid_valid_reg)
        else $error("result arrived with the skid stage full");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
